// ----- src/csg_pkg.sv -----
package csg_pkg;

  localparam int PHASE_BITS = 24;
  localparam int DIV_STEPS  = 16;
  localparam int NUM_W      = 56;
  localparam int DEN_W      = 43;

  // the value one on the doubled phase: the midpoint of a triangle cycle
  localparam logic [PHASE_BITS:0] TRI_FULL = {1'b1, {PHASE_BITS{1'b0}}};

  // OUTPUT_GAIN folded into the mix constants
  localparam logic [NUM_W-1:0] SQ_NUM_K  = 56'd115056000;     // 12000*9588
  localparam logic [DEN_W-1:0] SQ_DEN_K0 = 43'd812800;        // 100*8128
  localparam logic [NUM_W-1:0] TND_NUM_K = 56'd191748000;     // 12000*15979
  localparam logic signed [43:0] TND_DEN_K0 = 44'sd5156183398400; // 100*512*8227*12241

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_NOTE   = 2'd2,
    KIND_REST   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VOICE_SQ_A  = 2'd0,
    VOICE_SQ_B  = 2'd1,
    VOICE_TRI   = 2'd2,
    VOICE_NOISE = 2'd3
  } voice_t;

  typedef enum logic [2:0] {
    REG_SQ_A_DUTY = 3'd0,
    REG_SQ_B_DUTY = 3'd1,
    REG_SQ_A_ENV  = 3'd2,
    REG_SQ_B_ENV  = 3'd3,
    REG_NOISE_ENV = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_TND_START,
    ST_TND_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [3:0] level;
    logic [3:0] count;
    logic       restart;
  } env_t;

  // bit i of a row = duty output at eighth i of the cycle
  localparam logic [7:0] DUTY_ROWS [4] = '{8'b0000_0010, 8'b0000_0110,
                                           8'b0001_1110, 8'b1111_1001};

  localparam logic [11:0] NOISE_PERIODS [16] = '{
    12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
    12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068};

  function automatic env_t env_step(env_t e, logic [3:0] period);
    env_t r;
    r = e;
    if (e.restart) begin
      r.level   = 4'd15;
      r.count   = period;
      r.restart = 1'b0;
    end else if (e.level != 4'd0) begin
      if (e.count <= 4'd1) begin
        r.count = period;
        r.level = e.level - 4'd1;
      end else begin
        r.count = e.count - 4'd1;
      end
    end
    return r;
  endfunction

endpackage

// ----- src/csg_div.sv -----
// restoring divider, one quotient bit per cycle
module csg_div import csg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DIV_STEPS-1:0] quo
);

  localparam int SH_W  = DEN_W + DIV_STEPS - 1;
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [NUM_W-1:0]     rem_r;
  logic [SH_W-1:0]      dsh_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic                 ge;

  assign ge   = {{(SH_W-NUM_W){1'b0}}, rem_r} >= dsh_r;
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {(DIV_STEPS-1){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r[NUM_W-1:0];
      quo_r <= {quo_r[DIV_STEPS-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

// ----- src/chiptune_sound_generator.sv -----
// channel  | handshake                      | payload
// input    | in_valid / in_stall            | in_kind, in_voice, in_phase_step, in_noise_rate
// output   | out_valid / out_stall          | out_sample
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// Frame tick, note on and rest words finish in the cycle they are accepted.
// A sample word holds in_stall high from accept until its result is loaded into
// the output register, so the next word waits until then. Levels and voice
// state update at accept, then the shared 16-step divider runs twice (square mix,
// then triangle/noise mix), each run opened by a start state and closed by its done.
// The output register lets the next word in while a finished sample still waits
// on out_stall; a second finished sample holds in the output state meanwhile.
// rst_n is synchronous, active low; it clears control and voice state.
module chiptune_sound_generator import csg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_voice,
  input  logic [23:0] in_phase_step,
  input  logic [3:0]  in_noise_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_sample,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // config registers
  logic [1:0] duty_a_r, duty_b_r;
  logic [3:0] env_per_r [3];

  // voice state
  logic [PHASE_BITS-1:0] sq_phase_r [2];
  logic [PHASE_BITS-1:0] sq_step_r  [2];
  logic [PHASE_BITS-1:0] tri_phase_r, tri_step_r;
  logic                  tri_on_r;
  env_t                  env_r [3];
  logic [14:0]           nz_shift_r;
  logic [3:0]            nz_rate_r;
  logic [11:0]           nz_count_r;

  // mix datapath
  state_t state_r, state_nxt;
  logic [4:0]         s_r;
  logic signed [13:0] t_r;
  logic [3:0]         n_r;
  logic signed [28:0] x_r;
  logic [15:0]        part_sq_r;
  logic               out_valid_r;
  logic signed [15:0] out_sample_r;

  logic in_acc, cfg_wr;
  kind_t  kind;
  voice_t voice;

  assign kind     = kind_t'(in_kind);
  assign voice    = voice_t'(in_voice);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // ---- config port ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_a_r     <= 2'd1;
      duty_b_r     <= 2'd2;
      env_per_r[0] <= 4'd12;
      env_per_r[1] <= 4'd9;
      env_per_r[2] <= 4'd2;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_SQ_A_DUTY: duty_a_r     <= pwdata[1:0];
        REG_SQ_B_DUTY: duty_b_r     <= pwdata[1:0];
        REG_SQ_A_ENV:  env_per_r[0] <= pwdata[3:0];
        REG_SQ_B_ENV:  env_per_r[1] <= pwdata[3:0];
        REG_NOISE_ENV: env_per_r[2] <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx_t'(paddr[4:2]))
      REG_SQ_A_DUTY: prdata = {30'd0, duty_a_r};
      REG_SQ_B_DUTY: prdata = {30'd0, duty_b_r};
      REG_SQ_A_ENV:  prdata = {28'd0, env_per_r[0]};
      REG_SQ_B_ENV:  prdata = {28'd0, env_per_r[1]};
      REG_NOISE_ENV: prdata = {28'd0, env_per_r[2]};
      default:       prdata = '0;
    endcase
  end

  // ---- voice levels at the current phase ----
  logic [3:0]  lvl_a, lvl_b, lvl_n;
  logic [PHASE_BITS:0] tri_two, tri_dist;
  logic [9:0]  tri_a;
  logic signed [11:0] tri_v;
  logic signed [13:0] t_nxt;
  logic [12:0] nz_c;
  logic        nz_clk;
  logic [14:0] nz_shift_nxt;

  always_comb begin
    lvl_a = DUTY_ROWS[duty_a_r][sq_phase_r[0][PHASE_BITS-1 -: 3]] ? env_r[0].level : 4'd0;
    lvl_b = DUTY_ROWS[duty_b_r][sq_phase_r[1][PHASE_BITS-1 -: 3]] ? env_r[1].level : 4'd0;

    // triangle: |2p - 1| in 1/512 steps, then (2a - 512) * 15
    tri_two  = {tri_phase_r, 1'b0};
    tri_dist = tri_two[PHASE_BITS] ? (tri_two - TRI_FULL) : (TRI_FULL - tri_two);
    tri_a    = tri_dist[PHASE_BITS -: 10];
    tri_v    = $signed({1'b0, tri_a, 1'b0}) - 12'sd512;
    t_nxt    = tri_on_r ? 14'(14'(tri_v) * 14'sd15) : 14'sd0;

    // noise period counter and LFSR
    nz_c   = {1'b0, nz_count_r} + 13'd1;
    nz_clk = nz_c >= {1'b0, NOISE_PERIODS[nz_rate_r]};
    nz_shift_nxt = nz_clk ? {nz_shift_r[0] ^ nz_shift_r[1], nz_shift_r[14:1]} : nz_shift_r;
    lvl_n  = nz_shift_nxt[0] ? env_r[2].level : 4'd0;
  end

  // ---- voice state updates ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < 2; v++) begin
        sq_phase_r[v] <= '0;
        sq_step_r[v]  <= '0;
      end
      tri_phase_r <= '0;
      tri_step_r  <= '0;
      tri_on_r    <= 1'b1;
      for (int v = 0; v < 3; v++) env_r[v] <= '{level: 4'd0, count: 4'd0, restart: 1'b1};
      nz_shift_r <= '0;
      nz_rate_r  <= '0;
      nz_count_r <= '0;
    end else if (in_acc) begin
      case (kind)
        KIND_SAMPLE: begin
          sq_phase_r[0] <= sq_phase_r[0] + sq_step_r[0];
          sq_phase_r[1] <= sq_phase_r[1] + sq_step_r[1];
          if (tri_on_r) tri_phase_r <= tri_phase_r + tri_step_r;
          nz_shift_r <= nz_shift_nxt;
          nz_count_r <= nz_clk ? 12'd0 : nz_c[11:0];
        end
        KIND_FRAME: begin
          for (int v = 0; v < 3; v++) env_r[v] <= env_step(env_r[v], env_per_r[v]);
        end
        KIND_NOTE: begin
          case (voice)
            VOICE_SQ_A, VOICE_SQ_B: begin
              sq_step_r[voice[0]]  <= PHASE_BITS'(in_phase_step);
              sq_phase_r[voice[0]] <= '0;
              env_r[voice[0]].restart <= 1'b1;
            end
            VOICE_TRI: begin
              tri_on_r    <= 1'b1;
              tri_step_r  <= PHASE_BITS'(in_phase_step);
              tri_phase_r <= '0;
            end
            default: begin
              nz_shift_r <= 15'd1;
              nz_rate_r  <= in_noise_rate;
              env_r[2].restart <= 1'b1;
            end
          endcase
        end
        default: begin
          case (voice)
            VOICE_SQ_A, VOICE_SQ_B: env_r[voice[0]].level <= 4'd0;
            VOICE_TRI:              tri_on_r <= 1'b0;
            default:                env_r[2].level <= 4'd0;
          endcase
        end
      endcase
    end
  end

  // ---- sequencer ----
  logic div_start, div_done, sel_tnd, load_x, load_sq, load_out, out_free;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [15:0]      div_quo;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_acc && kind == KIND_SAMPLE) state_nxt = ST_SQ_START;
      ST_SQ_START:  state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT:   if (div_done) state_nxt = ST_TND_START;
      ST_TND_START: state_nxt = ST_TND_WAIT;
      ST_TND_WAIT:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    sel_tnd   = 1'b0;
    load_x    = 1'b0;
    load_sq   = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_SQ_START: begin
        div_start = 1'b1;
        load_x    = 1'b1;
      end
      ST_SQ_WAIT:   load_sq = div_done;
      ST_TND_START: begin
        div_start = 1'b1;
        sel_tnd   = 1'b1;
      end
      ST_OUT:       load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // divider operands: square mix, or triangle/noise mix by |X| (sign restored after)
  logic [27:0] x_abs;
  always_comb begin
    x_abs = x_r[28] ? 28'(-x_r) : 28'(x_r);
    if (sel_tnd) begin
      div_num = 56'(x_abs) * TND_NUM_K;
      div_den = 43'(TND_DEN_K0 + 44'(x_r) * 44'sd10000);
    end else begin
      div_num = 56'(s_r) * SQ_NUM_K;
      div_den = SQ_DEN_K0 + 43'(s_r) * 43'd10000;
    end
  end

  csg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic signed [16:0] part_tnd;
  logic signed [17:0] mix_sum;
  logic signed [15:0] mix_sat;
  always_comb begin
    part_tnd = x_r[28] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    mix_sum  = 18'($signed({1'b0, part_sq_r})) + 18'(part_tnd);
    if (mix_sum > 18'sd32767)       mix_sat = 16'sh7FFF;
    else if (mix_sum < -18'sd32768) mix_sat = 16'sh8000;
    else                            mix_sat = mix_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_SAMPLE) begin
      s_r <= 5'(lvl_a) + 5'(lvl_b);
      t_r <= t_nxt;
      n_r <= lvl_n;
    end
    if (load_x)
      x_r <= 29'(29'(t_r) * 29'sd12241) + 29'($signed({25'd0, n_r}) * 29'sd4212224);
    if (load_sq)  part_sq_r <= div_quo;
    if (load_out) out_sample_r <= mix_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        out_valid_r <= 1'b0;
    else if (load_out) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  // ---- checks ----
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("sample word raised outside output state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_SQ_WAIT || state_r == ST_TND_WAIT))
    else $error("divider finished while sequencer not waiting");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && kind == KIND_SAMPLE) |=> state_r == ST_SQ_START)
    else $error("sample tick did not start the mix");

endmodule

// ----- test/chiptune_sound_generator_tb.sv -----
`timescale 1ns / 1ps

// Four-voice sound generator bench.
// An initial block queues words (directed first, then random phases under
// several register settings); a clocked driver offers them, a clocked monitor
// checks each output sample against the sample model below.
module chiptune_sound_generator_tb;
  import csg_pkg::*;

  typedef struct {
    kind_t       kind;
    voice_t      voice;
    logic [23:0] step;
    logic [3:0]  rate;
  } apu_word_t;

  // DUT ports; the driven inputs are known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [1:0]  in_voice = '0;
  logic [23:0] in_phase_step = '0;
  logic [3:0]  in_noise_rate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chiptune_sound_generator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_voice(in_voice),
    .in_phase_step(in_phase_step), .in_noise_rate(in_noise_rate),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // ---------------- sample model state ----------------
  logic [1:0]  duty_a, duty_b;
  logic [3:0]  env_per [3];          // square a, square b, noise
  logic [23:0] sq_phase [2];
  logic [23:0] sq_step [2];
  logic [23:0] tri_phase, tri_step;
  logic        tri_on;
  env_t        env [3];
  logic [14:0] lfsr;
  logic [3:0]  lfsr_rate;
  logic [11:0] lfsr_count;

  // pending stimulus words and expected output samples
  apu_word_t           pending_words[$];
  logic signed [15:0]  expected_samples[$];

  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_idle = 0;   // percent of cycles the receiver stalls
  int errors = 0;
  int samples_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;
  apu_word_t cur;

  function automatic void model_reset();
    duty_a = 2'd1; duty_b = 2'd2;
    env_per[0] = 4'd12; env_per[1] = 4'd9; env_per[2] = 4'd2;
    sq_phase[0] = '0; sq_phase[1] = '0; sq_step[0] = '0; sq_step[1] = '0;
    tri_phase = '0; tri_step = '0; tri_on = 1'b1;
    for (int v = 0; v < 3; v++) env[v] = '{level: 4'd0, count: 4'd0, restart: 1'b1};
    lfsr = '0; lfsr_rate = '0; lfsr_count = '0;
  endfunction

  // Read squares and triangle at their current phase, then advance; noise steps first; nonlinear mix.
  function automatic logic signed [15:0] next_sample();
    logic [7:0]  row;
    longint      s, t, n, x, p_sq, p_tnd, sum;
    logic [24:0] two;
    logic [24:0] a;
    logic [11:0] c;
    s = 0;
    for (int v = 0; v < 2; v++) begin
      row = DUTY_ROWS[v == 0 ? duty_a : duty_b];
      if (row[sq_phase[v][23:21]]) s += env[v].level;
      sq_phase[v] = sq_phase[v] + sq_step[v];
    end
    t = 0;
    if (tri_on) begin
      two = {tri_phase, 1'b0};
      a = (two >= 25'h100_0000) ? two - 25'h100_0000 : 25'h100_0000 - two;
      a = a >> 15;
      t = (2 * longint'(a) - 512) * 15;
      tri_phase = tri_phase + tri_step;
    end
    // noise counter: the count plus one reaching the table period clocks the register
    c = lfsr_count + 12'd1;
    if (c >= NOISE_PERIODS[lfsr_rate]) begin
      lfsr = {lfsr[0] ^ lfsr[1], lfsr[14:1]};
      lfsr_count = '0;
    end else begin
      lfsr_count = c;
    end
    n = lfsr[0] ? env[2].level : 0;
    x = t * 12241 + n * 512 * 8227;
    p_sq = 0; p_tnd = 0;
    if (s != 0) p_sq = (longint'(12000) * 9588 * s) / (100 * (8128 + 100 * s));
    if (x != 0)
      p_tnd = (longint'(12000) * 15979 * x) / (100 * (longint'(512) * 8227 * 12241 + 100 * x));
    sum = p_sq + p_tnd;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return sum[15:0];
  endfunction

  function automatic void env_tick(int v);
    if (env[v].restart) begin
      env[v].level = 4'd15; env[v].count = env_per[v]; env[v].restart = 1'b0;
    end else if (env[v].level != 4'd0) begin
      if (env[v].count <= 4'd1) begin
        env[v].count = env_per[v];
        env[v].level = env[v].level - 4'd1;
      end else begin
        env[v].count = env[v].count - 4'd1;
      end
    end
  endfunction

  function automatic void apply_word(apu_word_t w);
    case (w.kind)
      KIND_SAMPLE: expected_samples.push_back(next_sample());
      KIND_FRAME: for (int v = 0; v < 3; v++) env_tick(v);
      KIND_NOTE: begin
        if (w.voice == VOICE_SQ_A || w.voice == VOICE_SQ_B) begin
          sq_step[w.voice] = w.step; sq_phase[w.voice] = '0;
          env[w.voice].restart = 1'b1;
        end else if (w.voice == VOICE_TRI) begin
          tri_on = 1'b1; tri_step = w.step; tri_phase = '0;
        end else begin
          lfsr = 15'd1; lfsr_rate = w.rate; env[2].restart = 1'b1;
        end
      end
      default: begin
        // rest keeps any pending envelope restart
        if (w.voice == VOICE_TRI) tri_on = 1'b0;
        else env[w.voice == VOICE_NOISE ? 2 : w.voice].level = 4'd0;
      end
    endcase
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_word(cur);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur = pending_words.pop_front();
          in_valid      <= 1'b1;
          in_kind       <= cur.kind;
          in_voice      <= cur.voice;
          in_phase_step <= cur.step;
          in_noise_rate <= cur.rate;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected sample, expected none, actual %0d", $time, out_sample);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want) begin
            errors++;
            $display("%0t: sample mismatch, expected %0d, actual %0d",
                     $time, want, out_sample);
          end
        end
      end
      // one long hold-off so the sender backs up against in_stall
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && samples_seen >= 150) begin
        hold_done = 1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic apu_word_t mk(kind_t k, voice_t v, logic [23:0] s, logic [3:0] r);
    apu_word_t w;
    w.kind = k; w.voice = v; w.step = s; w.rate = r;
    return w;
  endfunction

  function automatic logic [23:0] rand_step();
    case ($urandom_range(3))
      0: return 24'($urandom_range(24'hFFFF));
      1: return 24'($urandom);
      2: return 24'(24'h100000 + $urandom_range(24'h0FFFFF));
      default: return $urandom_range(3) == 0 ? 24'hFFFFFF : 24'($urandom_range(24'h3FFFF));
    endcase
  endfunction

  function automatic apu_word_t rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 60) return mk(KIND_SAMPLE, voice_t'($urandom_range(3)), 24'($urandom),
                          4'($urandom));
    if (r < 78) return mk(KIND_FRAME, voice_t'($urandom_range(3)), 24'($urandom),
                          4'($urandom));
    if (r < 92) return mk(KIND_NOTE, voice_t'($urandom_range(3)), rand_step(),
                          4'($urandom));
    return mk(KIND_REST, voice_t'($urandom_range(3)), 24'($urandom), 4'($urandom));
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [3:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SQ_A_DUTY: duty_a = val[1:0];
      REG_SQ_B_DUTY: duty_b = val[1:0];
      REG_SQ_A_ENV:  env_per[0] = val;
      REG_SQ_B_ENV:  env_per[1] = val;
      default:       env_per[2] = val;
    endcase
  endtask

  task automatic write_all(logic [1:0] da, logic [1:0] db, logic [3:0] ea,
                           logic [3:0] eb, logic [3:0] en);
    reg_write(REG_SQ_A_DUTY, 4'(da));
    reg_write(REG_SQ_B_DUTY, 4'(db));
    reg_write(REG_SQ_A_ENV, ea);
    reg_write(REG_SQ_B_ENV, eb);
    reg_write(REG_NOISE_ENV, en);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) pending_words.push_back(rand_word());
    drain();
  endtask

  initial begin
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset state, first samples before any note, extremes
    pending_words.push_back(mk(KIND_SAMPLE, VOICE_SQ_A, 24'h0, 4'h0));   // squares silent, noise zeroed
    pending_words.push_back(mk(KIND_FRAME, VOICE_SQ_A, 24'h0, 4'h0));    // pending restarts fire
    pending_words.push_back(mk(KIND_SAMPLE, VOICE_SQ_B, 24'h0, 4'h0));
    pending_words.push_back(mk(KIND_NOTE, VOICE_SQ_A, 24'hFFFFFF, 4'h0));
    pending_words.push_back(mk(KIND_NOTE, VOICE_SQ_B, 24'h200000, 4'h0));
    pending_words.push_back(mk(KIND_NOTE, VOICE_TRI, 24'hFFFFFF, 4'h0));
    pending_words.push_back(mk(KIND_NOTE, VOICE_NOISE, 24'h0, 4'h0));   // shortest noise period
    pending_words.push_back(mk(KIND_FRAME, VOICE_TRI, 24'h0, 4'h0));
    for (int i = 0; i < 6; i++)
      pending_words.push_back(mk(KIND_SAMPLE, VOICE_NOISE, 24'hFFFFFF, 4'hF));
    pending_words.push_back(mk(KIND_REST, VOICE_SQ_A, 24'h0, 4'h0));     // level zeroed, restart flag untouched
    pending_words.push_back(mk(KIND_REST, VOICE_TRI, 24'h0, 4'h0));      // triangle frozen
    pending_words.push_back(mk(KIND_SAMPLE, VOICE_SQ_A, 24'h0, 4'h0));
    pending_words.push_back(mk(KIND_REST, VOICE_NOISE, 24'h0, 4'h0));
    pending_words.push_back(mk(KIND_REST, VOICE_SQ_B, 24'hFFFFFF, 4'hF));
    pending_words.push_back(mk(KIND_SAMPLE, VOICE_SQ_A, 24'h0, 4'h0));
    pending_words.push_back(mk(KIND_NOTE, VOICE_NOISE, 24'hFFFFFF, 4'hF)); // longest period
    pending_words.push_back(mk(KIND_NOTE, VOICE_TRI, 24'h0, 4'h0));       // step zero
    pending_words.push_back(mk(KIND_FRAME, VOICE_NOISE, 24'h0, 4'h0));
    pending_words.push_back(mk(KIND_SAMPLE, VOICE_TRI, 24'h0, 4'h0));
    drain();

    // random phases; registers rewritten only when idle
    send_idle = 38; recv_idle = 78;
    run_random(360);
    write_all(2'd0, 2'd0, 4'd0, 4'd0, 4'd0);      // low extremes
    send_idle = 78; recv_idle = 38;
    run_random(360);
    write_all(2'd3, 2'd3, 4'd15, 4'd15, 4'd15);   // high extremes
    send_idle = 0; recv_idle = 0;
    run_random(360);
    write_all(2'($urandom), 2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
    send_idle = 38; recv_idle = 78;
    run_random(350);

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
